// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed: next-cycle implication");

`endif

// ----- design/c2u_pkg.sv -----
// ----------------------------------------------------------------------------
// Calendar to Unix seconds package
// Shared constants, the month start table and pipeline control types.
// ----------------------------------------------------------------------------
`default_nettype none

package c2u_pkg;

	localparam logic [11:0] EpochYear   = 12'd1970;
	localparam logic [31:0] DaysPerYear = 32'd365;
	localparam logic [31:0] LeapsBefore = 32'd477;
	localparam logic [31:0] SecPerDay   = 32'd86400;
	localparam logic [16:0] SecPerHour  = 17'd3600;
	localparam logic [16:0] SecPerMin   = 17'd60;
	localparam logic [24:0] Recip100    = 25'd5243;
	localparam int          RecipShift  = 19;
	localparam logic [11:0] Hundred     = 12'd100;
	localparam logic [11:0] FourHundred = 12'd400;

	typedef struct packed {
		logic load_s1;
		logic load_s2;
	} c2u_load_t;

	function automatic logic [8:0] month_start(input logic [3:0] month);
		logic [8:0] days;
		case (month)
			4'd0:    days = 9'd0;
			4'd1:    days = 9'd0;
			4'd2:    days = 9'd31;
			4'd3:    days = 9'd59;
			4'd4:    days = 9'd90;
			4'd5:    days = 9'd120;
			4'd6:    days = 9'd151;
			4'd7:    days = 9'd181;
			4'd8:    days = 9'd212;
			4'd9:    days = 9'd243;
			4'd10:   days = 9'd273;
			4'd11:   days = 9'd304;
			4'd12:   days = 9'd334;
			default: days = 9'd365;
		endcase
		return days;
	endfunction

endpackage

`default_nettype wire

// ----- design/c2u_day_count.sv -----
// ----------------------------------------------------------------------------
// Day count stages
// Turns a calendar date into a day count since the epoch and the time of day
// into seconds, over two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module c2u_day_count (
	input  wire logic               clk,
	input  wire c2u_pkg::c2u_load_t load,
	input  wire logic [11:0]        cal_year,
	input  wire logic [3:0]         cal_month,
	input  wire logic [4:0]         cal_day,
	input  wire logic [4:0]         cal_hour,
	input  wire logic [5:0]         cal_minute,
	input  wire logic [5:0]         cal_second,
	output logic [31:0]             days_s2,
	output logic [16:0]             hms_s2
);

	logic [11:0] year_m1;
	logic [24:0] nm1_prod100;
	logic [24:0] nm1_prod400;
	logic [24:0] yr_prod100;
	logic [24:0] yr_prod400;

	logic        later_s1;
	logic [11:0] whole_s1;
	logic [9:0]  q4_s1;
	logic [5:0]  q100_s1;
	logic [3:0]  q400_s1;
	logic [11:0] year_s1;
	logic [5:0]  yq100_s1;
	logic [3:0]  yq400_s1;
	logic [8:0]  month_days_s1;
	logic        month_late_s1;
	logic [4:0]  day_s1;
	logic [16:0] hms_s1;

	logic        leap;
	logic [31:0] year_days;
	logic [31:0] days;

	assign year_m1     = cal_year - 12'd1;
	assign nm1_prod100 = {13'd0, year_m1} * c2u_pkg::Recip100;
	assign nm1_prod400 = {15'd0, year_m1[11:2]} * c2u_pkg::Recip100;
	assign yr_prod100  = {13'd0, cal_year} * c2u_pkg::Recip100;
	assign yr_prod400  = {15'd0, cal_year[11:2]} * c2u_pkg::Recip100;

	always_ff @(posedge clk) begin
		if (load.load_s1) begin
			later_s1      <= cal_year > c2u_pkg::EpochYear;
			whole_s1      <= cal_year - c2u_pkg::EpochYear;
			q4_s1         <= year_m1[11:2];
			q100_s1       <= nm1_prod100[c2u_pkg::RecipShift +: 6];
			q400_s1       <= nm1_prod400[c2u_pkg::RecipShift +: 4];
			year_s1       <= cal_year;
			yq100_s1      <= yr_prod100[c2u_pkg::RecipShift +: 6];
			yq400_s1      <= yr_prod400[c2u_pkg::RecipShift +: 4];
			month_days_s1 <= c2u_pkg::month_start(cal_month);
			month_late_s1 <= cal_month > 4'd2;
			day_s1        <= cal_day;
			hms_s1        <= {12'd0, cal_hour} * c2u_pkg::SecPerHour
				+ {11'd0, cal_minute} * c2u_pkg::SecPerMin
				+ {11'd0, cal_second};
		end
	end

	always_comb begin
		leap = (year_s1[1:0] == 2'd0)
			&& ((year_s1 != {6'd0, yq100_s1} * c2u_pkg::Hundred)
			|| (year_s1 == {8'd0, yq400_s1} * c2u_pkg::FourHundred));
		if (later_s1) begin
			year_days = {20'd0, whole_s1} * c2u_pkg::DaysPerYear
				+ {22'd0, q4_s1} - {26'd0, q100_s1} + {28'd0, q400_s1}
				- c2u_pkg::LeapsBefore;
		end else begin
			year_days = 32'd0;
		end
		days = year_days + {23'd0, month_days_s1} + {31'd0, month_late_s1 & leap}
			+ {27'd0, day_s1} - 32'd1;
	end

	always_ff @(posedge clk) begin
		if (load.load_s2) begin
			days_s2 <= days;
			hms_s2  <= hms_s1;
		end
	end

endmodule

`default_nettype wire

// ----- design/calendar_to_unix_seconds_unit.sv -----
// ----------------------------------------------------------------------------
// Calendar to Unix seconds unit
// Converts a Gregorian date and time of day into seconds since 1970-01-01.
// ----------------------------------------------------------------------------
// The input channel (cal_valid, cal_stall) carries one date and time per
// transaction: year, month, day, hour, minute and second. The output channel
// (epoch_valid, epoch_stall) carries one 32-bit seconds count per input
// transaction, in the same order.
// An accepted input passes through four stages to epoch_valid: day count
// terms, day count sum, the multiply by 86400, and the final add of the time
// of day. One transaction can enter every cycle while cal_stall is low, so
// throughput is one per cycle when epoch_stall does not hold the pipeline.
// Each stage holds its own valid bit and advances whenever the stage ahead is
// empty or moving, so a stall on the output fills the bubbles first and only
// then raises cal_stall. Nothing is dropped or repeated.
// Reset clears all valid bits; no output is presented until a new input has
// been accepted. Years after 2105 wrap modulo 2^32, and years before 1970
// count no whole years.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module calendar_to_unix_seconds_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cal_valid,
	output logic             cal_stall,
	input  wire logic [11:0] cal_year,
	input  wire logic [3:0]  cal_month,
	input  wire logic [4:0]  cal_day,
	input  wire logic [4:0]  cal_hour,
	input  wire logic [5:0]  cal_minute,
	input  wire logic [5:0]  cal_second,
	output logic             epoch_valid,
	input  wire logic        epoch_stall,
	output logic [31:0]      epoch_seconds
);

	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic               valid_s4;
	logic               ready_s1;
	logic               ready_s2;
	logic               ready_s3;
	logic               ready_s4;
	logic               accept;
	c2u_pkg::c2u_load_t load;
	logic [31:0]        days_s2;
	logic [16:0]        hms_s2;
	logic [31:0]        prod_s3;
	logic [16:0]        hms_s3;

	assign ready_s4  = !valid_s4 || !epoch_stall;
	assign ready_s3  = !valid_s3 || ready_s4;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign accept    = cal_valid && ready_s1;
	assign cal_stall = !ready_s1;

	assign load.load_s1 = accept;
	assign load.load_s2 = valid_s1 && ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= cal_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	c2u_day_count u_day_count (
		.clk        (clk),
		.load       (load),
		.cal_year   (cal_year),
		.cal_month  (cal_month),
		.cal_day    (cal_day),
		.cal_hour   (cal_hour),
		.cal_minute (cal_minute),
		.cal_second (cal_second),
		.days_s2    (days_s2),
		.hms_s2     (hms_s2)
	);

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			prod_s3 <= days_s2 * c2u_pkg::SecPerDay;
			hms_s3  <= hms_s2;
		end
		if (valid_s3 && ready_s4) begin
			epoch_seconds <= prod_s3 + {15'd0, hms_s3};
		end
	end

	assign epoch_valid = valid_s4;

	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, accept, valid_s1)
	`ASSERT_NEXT(a_stall_holds_s3, clk, arst_n, valid_s4 && epoch_stall && valid_s3, valid_s3 && $stable(prod_s3))
	`ASSERT_NEXT(a_drain_empties, clk, arst_n, valid_s4 && !epoch_stall && !valid_s3, !epoch_valid)
	`ASSERT_SAME(a_stall_needs_full, clk, arst_n, cal_stall, valid_s1 && valid_s2 && valid_s3 && valid_s4)

endmodule

`default_nettype wire
